// ===== hdl/chm_pkg.sv =====
package chm_pkg;

    localparam int BUCKETS = 64;
    localparam int NODES   = 256;

    localparam int B_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IDX_W   = $clog2(NODES);
    localparam int PTR_W   = $clog2(NODES + 1);
    localparam int DIV_W   = $clog2(BUCKETS + 1);
    localparam int BC_W    = 7;
    localparam int CNT_W   = 9;
    localparam int CHUNK   = (NODES < 32) ? NODES : 32;
    localparam int CHUNKS  = NODES / CHUNK;
    localparam int CH_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CI_W    = $clog2(CHUNK);

    localparam logic [PTR_W-1:0] PTR_NULL  = PTR_W'(NODES);
    localparam logic [BC_W-1:0]  BC_RESET  = BC_W'(64);

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FAIL = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_START,
        S_FETCH,
        S_CHECK,
        S_ALLOC,
        S_LINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key;
        logic [31:0]        value_in;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [31:0]      value_out;
        logic [CNT_W-1:0] entry_count;
    } t_out;

    typedef struct packed {
        logic             start;
        logic             clear;
        logic             take;
        logic             give_back;
        logic [IDX_W-1:0] idx;
    } t_alloc_ctl;

    typedef struct packed {
        logic             done;
        logic             ok;
        logic [IDX_W-1:0] idx;
    } t_alloc_res;

endpackage

// ===== hdl/chm_mod.sv =====
module chm_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [31:0]         i_key,
    input  logic [chm_pkg::DIV_W-1:0]  i_div,
    output logic                       o_done,
    output logic [chm_pkg::B_W-1:0]    o_bucket
);
    import chm_pkg::*;

    logic              r_busy, r_fin, r_neg;
    logic [4:0]        r_cnt;
    logic [31:0]       r_mag;
    logic [DIV_W-1:0]  r_rem, r_div;
    logic [DIV_W:0]    w_t;
    logic [DIV_W-1:0]  w_adj;

    // restoring remainder, one key bit a cycle
    assign w_t   = {r_rem, r_mag[31]};
    assign w_adj = (r_neg && r_rem != '0) ? DIV_W'(r_div - r_rem) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_div;
                r_neg  <= i_key[31];
                r_mag  <= i_key[31] ? 32'(-i_key) : 32'(i_key);
            end else if (r_busy) begin
                r_mag <= {r_mag[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (w_t >= {1'b0, r_div})
                    r_rem <= DIV_W'(w_t - {1'b0, r_div});
                else
                    r_rem <= DIV_W'(w_t);
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_fin;
    assign o_bucket = B_W'(w_adj);

endmodule

// ===== hdl/chm_alloc.sv =====
module chm_alloc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  chm_pkg::t_alloc_ctl   i_ctl,
    output chm_pkg::t_alloc_res   o_res
);
    import chm_pkg::*;

    logic [NODES-1:0] r_free;
    logic             r_busy;
    logic [CH_W-1:0]  r_chunk;
    logic [CHUNK-1:0] w_bits;
    logic             w_any;
    logic [CI_W-1:0]  w_pos;

    assign w_bits = r_free[r_chunk * CHUNK +: CHUNK];

    always_comb begin
        w_any = 1'b0;
        w_pos = '0;
        for (int i = CHUNK - 1; i >= 0; i--) begin
            if (w_bits[i]) begin
                w_any = 1'b1;
                w_pos = CI_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
            r_busy <= 1'b0;
        end else begin
            if (i_ctl.clear)
                r_free <= '1;
            else if (i_ctl.take)
                r_free[i_ctl.idx] <= 1'b0;
            else if (i_ctl.give_back)
                r_free[i_ctl.idx] <= 1'b1;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_chunk <= '0;
            end else if (r_busy) begin
                if (w_any || r_chunk == CH_W'(CHUNKS - 1))
                    r_busy <= 1'b0;
                else
                    r_chunk <= r_chunk + 1'b1;
            end
        end
    end

    assign o_res.done = r_busy && (w_any || r_chunk == CH_W'(CHUNKS - 1));
    assign o_res.ok   = w_any;
    assign o_res.idx  = IDX_W'({r_chunk, w_pos});

endmodule

// ===== hdl/chained_hash_map_integer_key_core.sv =====
// Key-value map on signed 32-bit keys, separate chaining over a pool of NODES nodes.
// One operation at a time: o_stall is high from acceptance until the result is
// registered. After acceptance an item passes through the bucket remainder (one key bit
// per cycle in the remainder unit, plus load and hand-over), a bucket-head read, a
// registered node memory read per chain node visited, and for a put of a new key a
// free-node scan chunk by chunk (the node is written when a free one is found) plus a
// link step; a last step registers the result, held longer while the output is stalled.
// A clear goes straight to that last step.
// No clearing pass after reset: head and node-free flags reset at once.
module chained_hash_map_integer_key_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  chm_pkg::t_in             i_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output chm_pkg::t_out            o_data,
    input  logic                     i_cfg_we,
    input  logic [chm_pkg::BC_W-1:0] i_cfg_wdata
);
    import chm_pkg::*;

    t_state r_state, n_state;

    logic [1:0]         r_op, n_op;
    logic signed [31:0] r_key, n_key;
    logic [31:0]        r_val, n_val;
    logic [B_W-1:0]     r_bucket, n_bucket;
    logic [PTR_W-1:0]   r_cur, n_cur, r_prev, n_prev;
    t_out               r_res, n_res, r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [CNT_W-1:0]   r_entries, n_entries;
    logic [BC_W-1:0]    r_bc;
    logic [BUCKETS-1:0] r_hv;

    logic [PTR_W-1:0]   r_head_mem [BUCKETS];
    logic [31:0]        r_key_mem  [NODES];
    logic [31:0]        r_val_mem  [NODES];
    logic [PTR_W-1:0]   r_link_mem [NODES];
    logic [PTR_W-1:0]   r_head_rd, r_link_rd;
    logic [31:0]        r_key_rd, r_val_rd;

    logic               head_we, link_we, node_we, val_we, hv_clear;
    logic [B_W-1:0]     head_wa;
    logic [PTR_W-1:0]   head_wd, link_wd;
    logic [IDX_W-1:0]   link_wa, val_wa;
    logic [31:0]        val_wd;

    logic               w_accept, w_hit, w_head_null, w_load;
    logic [PTR_W-1:0]   w_head;
    logic [DIV_W-1:0]   w_div;
    logic               mod_start, mod_done;
    logic [B_W-1:0]     mod_bucket;
    t_alloc_ctl         actl;
    t_alloc_res         ares;

    assign w_accept    = i_valid && (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE);
    assign w_head      = r_hv[r_bucket] ? r_head_rd : PTR_NULL;
    assign w_head_null = (w_head == PTR_NULL);
    assign w_hit       = (r_key_rd == 32'(r_key));
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        if (r_bc == '0)
            w_div = DIV_W'(1);
        else if (32'(r_bc) > 32'(BUCKETS))
            w_div = DIV_W'(BUCKETS);
        else
            w_div = DIV_W'(r_bc);
    end

    // the remainder unit loads its key on the accepting edge
    chm_mod u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mod_start),
        .i_key    (i_data.key),
        .i_div    (w_div),
        .o_done   (mod_done),
        .o_bucket (mod_bucket)
    );

    chm_alloc u_alloc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (actl),
        .o_res   (ares)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = (i_data.opcode == OP_CLEAR) ? S_DONE : S_HASH;
            S_HASH:  if (mod_done) n_state = S_HEAD;
            S_HEAD:  n_state = S_START;
            S_START: begin
                if (!w_head_null)     n_state = S_FETCH;
                else if (r_op == OP_PUT) n_state = S_ALLOC;
                else                  n_state = S_DONE;
            end
            S_FETCH: n_state = S_CHECK;
            S_CHECK: begin
                if (w_hit)                     n_state = S_DONE;
                else if (r_link_rd != PTR_NULL) n_state = S_FETCH;
                else if (r_op == OP_PUT)        n_state = S_ALLOC;
                else                           n_state = S_DONE;
            end
            S_ALLOC: if (ares.done) n_state = ares.ok ? S_LINK : S_DONE;
            S_LINK:  n_state = S_DONE;
            S_DONE:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_op        = r_op;
        n_key       = r_key;
        n_val       = r_val;
        n_bucket    = r_bucket;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_res       = r_res;
        n_entries   = r_entries;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mod_start   = 1'b0;
        actl        = '0;
        hv_clear    = 1'b0;
        head_we     = 1'b0;
        head_wa     = r_bucket;
        head_wd     = r_cur;
        link_we     = 1'b0;
        link_wa     = r_prev[IDX_W-1:0];
        link_wd     = r_cur;
        node_we     = 1'b0;
        val_we      = 1'b0;
        val_wa      = r_cur[IDX_W-1:0];
        val_wd      = r_val;

        if (r_out_valid && !i_stall)
            n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = i_data.opcode;
                    n_key = i_data.key;
                    n_val = i_data.value_in;
                    n_res = '{status: ST_OK, found: 1'b0, value_out: '0, entry_count: '0};
                    if (i_data.opcode == OP_CLEAR) begin
                        hv_clear   = 1'b1;
                        actl.clear = 1'b1;
                        n_entries  = '0;
                    end else begin
                        mod_start = 1'b1;
                    end
                end
            end
            S_HASH: if (mod_done) n_bucket = mod_bucket;
            S_START: begin
                n_cur  = w_head;
                n_prev = PTR_NULL;
                if (w_head_null) begin
                    if (r_op == OP_PUT) actl.start = 1'b1;
                    else                n_res.status = ST_FAIL;
                end
            end
            S_CHECK: begin
                if (w_hit) begin
                    case (r_op)
                        OP_GET: begin
                            n_res.found     = 1'b1;
                            n_res.value_out = r_val_rd;
                        end
                        OP_PUT: begin
                            if (r_val_rd == r_val) n_res.status = ST_FAIL;
                            else                   val_we = 1'b1;
                        end
                        default: begin
                            // unlink: predecessor or head takes the successor
                            if (r_prev == PTR_NULL) begin
                                head_we = 1'b1;
                                head_wd = r_link_rd;
                            end else begin
                                link_we = 1'b1;
                                link_wd = r_link_rd;
                            end
                            actl.give_back = 1'b1;
                            actl.idx       = r_cur[IDX_W-1:0];
                            if (r_entries != '0) n_entries = r_entries - 1'b1;
                        end
                    endcase
                end else begin
                    n_prev = r_cur;
                    n_cur  = r_link_rd;
                    if (r_link_rd == PTR_NULL) begin
                        if (r_op == OP_PUT) actl.start = 1'b1;
                        else                n_res.status = ST_FAIL;
                    end
                end
            end
            S_ALLOC: begin
                if (ares.done) begin
                    if (!ares.ok) begin
                        n_res.status = ST_FULL;
                    end else begin
                        node_we   = 1'b1;
                        val_we    = 1'b1;
                        val_wa    = ares.idx;
                        link_we   = 1'b1;
                        link_wa   = ares.idx;
                        link_wd   = PTR_NULL;
                        actl.take = 1'b1;
                        actl.idx  = ares.idx;
                        n_cur     = PTR_W'(ares.idx);
                        n_entries = r_entries + 1'b1;
                    end
                end
            end
            S_LINK: begin
                if (r_prev == PTR_NULL) head_we = 1'b1;
                else                    link_we = 1'b1;
            end
            S_DONE: begin
                if (w_load) begin
                    n_out             = r_res;
                    n_out.entry_count = r_entries;
                    n_out_valid       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_entries   <= '0;
            r_bc        <= BC_RESET;
            r_hv        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_entries   <= n_entries;
            if (i_cfg_we)
                r_bc <= i_cfg_wdata;
            if (hv_clear)
                r_hv <= '0;
            else if (head_we)
                r_hv[head_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_bucket <= n_bucket;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (head_we)
            r_head_mem[head_wa] <= head_wd;
        r_head_rd <= r_head_mem[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (node_we)
            r_key_mem[val_wa] <= 32'(r_key);
        r_key_rd <= r_key_mem[r_cur[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (val_we)
            r_val_mem[val_wa] <= val_wd;
        r_val_rd <= r_val_mem[r_cur[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (link_we)
            r_link_mem[link_wa] <= link_wd;
        r_link_rd <= r_link_mem[r_cur[IDX_W-1:0]];
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_entries) <= NODES)
        else $error("entry count above pool size");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.opcode == OP_CLEAR) |=> (r_entries == '0 && r_hv == '0))
        else $error("clear left entries behind");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not registered on leaving done");

endmodule

// ===== bench/chm_checker.sv =====
module chm_checker
    import chm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_stall_in,
    input  t_in              i_data,
    input  logic             o_valid,
    input  logic             i_stall_out,
    input  t_out             o_data,
    input  logic             i_cfg_we,
    input  logic [BC_W-1:0]  i_cfg_wdata,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [BC_W-1:0]  divisor_reg;
    logic [PTR_W-1:0] heads [BUCKETS];
    logic [31:0]      keys [NODES];
    logic [31:0]      vals [NODES];
    logic [PTR_W-1:0] links [NODES];
    logic             free_n [NODES];
    logic [CNT_W-1:0] held;
    t_out             results_q [$];

    function automatic int bucket_for(logic signed [31:0] k);
        longint n;
        longint r;
        n = divisor_reg;
        if (n < 1) n = 1;
        if (n > BUCKETS) n = BUCKETS;
        r = ((longint'(k) % n) + n) % n;
        return int'(r);
    endfunction

    task automatic empty_map();
        for (int i = 0; i < BUCKETS; i++) heads[i] = PTR_NULL;
        for (int i = 0; i < NODES; i++) begin
            free_n[i] = 1'b1;
            links[i] = PTR_NULL;
        end
        held = '0;
    endtask

    task automatic apply_op(t_in it);
        t_out r;
        int b;
        int cur;
        int prev;
        int steps;
        int slot;
        bit hit;
        r = '0;
        hit = 0;
        if (t_op'(it.opcode) == OP_CLEAR) begin
            empty_map();
        end else begin
            b = bucket_for(it.key);
            cur = heads[b];
            prev = NODES;
            steps = 0;
            while (cur < NODES && steps < NODES) begin
                if (keys[cur] == it.key) begin
                    hit = 1;
                    break;
                end
                prev = cur;
                cur = links[cur];
                steps++;
            end
            case (t_op'(it.opcode))
                OP_PUT: begin
                    if (hit) begin
                        if (vals[cur] == it.value_in) r.status = ST_FAIL;
                        else vals[cur] = it.value_in;
                    end else begin
                        slot = NODES;
                        for (int i = 0; i < NODES; i++)
                            if (free_n[i]) begin
                                slot = i;
                                break;
                            end
                        if (slot >= NODES) begin
                            r.status = ST_FULL;
                        end else begin
                            free_n[slot] = 1'b0;
                            keys[slot] = it.key;
                            vals[slot] = it.value_in;
                            links[slot] = PTR_NULL;
                            if (prev < NODES) links[prev] = PTR_W'(slot);
                            else heads[b] = PTR_W'(slot);
                            held++;
                        end
                    end
                end
                OP_GET: begin
                    if (hit) begin
                        r.found = 1'b1;
                        r.value_out = vals[cur];
                    end else begin
                        r.status = ST_FAIL;
                    end
                end
                default: begin
                    if (hit) begin
                        if (prev < NODES) links[prev] = links[cur];
                        else heads[b] = links[cur];
                        free_n[cur] = 1'b1;
                        if (held > 0) held--;
                    end else begin
                        r.status = ST_FAIL;
                    end
                end
            endcase
        end
        r.entry_count = held;
        results_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            divisor_reg = BC_RESET;
            empty_map();
            results_q.delete();
            o_errors <= 0;
        end else begin
            // config and input never coincide, so the blocking divisor update is safe
            if (i_cfg_we) divisor_reg = i_cfg_wdata;
            if (i_valid && !i_stall_in) apply_op(i_data);
            if (o_valid && !i_stall_out) begin
                if (results_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected transfer: got %p", o_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = results_q.pop_front();
                    if (want !== o_data) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %p got %p", want, o_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = results_q.size();
endmodule

// ===== bench/chained_hash_map_integer_key_core_tb.sv =====
module chained_hash_map_integer_key_core_tb;
    import chm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_stall;
    t_in             i_data = '0;
    logic            o_valid;
    logic            i_stall = 1'b0;
    t_out            o_data;
    logic            i_cfg_we = 1'b0;
    logic [BC_W-1:0] i_cfg_wdata = '0;
    int              errors;
    int              pending;
    int              idle_cycles = 0;
    int              out_wait = 0;
    bit              timed_out = 0;
    logic [31:0]     key_pool [16];

    localparam int WATCHDOG = 20000;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    chained_hash_map_integer_key_core u_top (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_valid, .i_stall, .o_data, .i_cfg_we, .i_cfg_wdata
    );

    chm_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_data,
        .o_valid, .i_stall_out(i_stall), .o_data, .i_cfg_we, .i_cfg_wdata,
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: after each transfer, stall for a drawn number of cycles
    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            out_wait <= 0;
        end else if (o_valid && !i_stall) begin
            draw = $urandom_range(0, 3);
            out_wait <= draw;
            i_stall  <= (draw != 0);
        end else if (out_wait != 0) begin
            out_wait <= out_wait - 1;
            i_stall  <= (out_wait > 1);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid stays up into the next item when no gap is drawn
    task automatic send(t_op op, logic [31:0] k, logic [31:0] v);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{opcode: op, key: k, value_in: v};
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic set_buckets(logic [BC_W-1:0] n);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom();
            default: return key_pool[$urandom_range(0, 15)];
        endcase
    endfunction

    initial begin
        logic [BC_W-1:0] bc_list [6] = '{7'd1, 7'd0, 7'd127, 7'd7, 7'd64, 7'd33};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, duplicates, negative keys, remove and clear
        send(OP_GET, 32'h8000_0000, 0);
        send(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
        send(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
        send(OP_PUT, 32'h8000_0000, 32'h0);
        send(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
        send(OP_PUT, 32'hFFFF_FFFF, 32'h5);
        send(OP_PUT, 32'h0000_003F, 32'h6);
        send(OP_PUT, 32'hFFFF_FFC1, 32'h7);
        send(OP_GET, 32'hFFFF_FFC1, 0);
        send(OP_GET, 32'h7FFF_FFFF, 0);
        send(OP_GET, 32'h0, 0);
        send(OP_REMOVE, 32'h0000_003F, 0);
        send(OP_REMOVE, 32'h0000_003F, 0);
        send(OP_GET, 32'hFFFF_FFC1, 0);
        send(OP_CLEAR, $urandom(), $urandom());
        send(OP_GET, 32'h8000_0000, 0);
        // fill the pool to hit the full status, then clear
        for (int i = 0; i < NODES + 2; i++) send(OP_PUT, i * 3, $urandom());
        send(OP_REMOVE, 32'd3, 0);
        send(OP_PUT, 32'd100000, 32'd9);
        send(OP_CLEAR, 0, 0);

        for (int phase = 0; phase < 6; phase++) begin
            set_buckets(bc_list[phase]);
            for (int i = 0; i < 16; i++)
                key_pool[i] = (i < 4) ? $urandom() : $urandom_range(0, 200) - 100;
            for (int n = 0; n < 120; n++) begin
                t_op op;
                case ($urandom_range(0, 19))
                    0: op = OP_CLEAR;
                    1, 2, 3, 4, 5, 6, 7, 8: op = OP_PUT;
                    9, 10, 11, 12, 13, 14: op = OP_GET;
                    default: op = OP_REMOVE;
                endcase
                if (n == 60) drain();
                send(op, pick_key(), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom());
            end
        end

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
